[rtl/bta_pkg.sv]
// Shared types and constants for the boundary-tag first-fit allocator.
package bta_pkg;

    localparam int HEAP_WORDS_DEF  = 4096;
    localparam int REQ_W           = 15;
    localparam int ADDR_W          = 14;
    localparam int NSIZE_W         = 16;
    localparam int TAG_PAIR_BYTES  = 8;
    localparam int MIN_SPLIT_BYTES = 8;
    localparam int BOUND_TAG       = 1;
    localparam int INIT_TOP        = 2;

    localparam logic MODE_FREE       = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        logic              status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_INIT0,
        ST_INIT1,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_GROW,
        ST_F_CHK,
        ST_F_HDR,
        ST_F_NRD,
        ST_F_NXT,
        ST_F_PRV,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_SPLIT,
        TAIL_EPILOGUE
    } tail_t;

endpackage

[rtl/bta_if.sv]
// Request and response channel interfaces with valid/ready handshake.
interface bta_req_if;
    logic          valid;
    logic          ready;
    bta_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bta_rsp_if;
    logic          valid;
    logic          ready;
    bta_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/bta_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/boundary_tag_first_fit_allocator_top.sv]
// Top level of the boundary-tag first-fit heap allocator.
//
// req channel: mode 0 allocates request_bytes of payload, mode 1 frees the
// block whose payload starts at free_address. rsp channel: one response per
// request, payload_address (0 on free and on no space) and status.
// The heap tags live in one RAM with registered read data; every step of
// the walk is a read followed by a check, so the single RAM read port sets
// the pace.
// Allocate walks the blocks from the prologue, reading and checking each;
// it writes the first free block that fits (and the split-off rest), else
// grows the heap at its top with a new epilogue, or answers no space. Free
// checks the address and stops on one outside the heap; else it reads the
// header and both neighbours and writes the merged block. One request is
// in work at a time.
// After reset the block writes the prologue and the first epilogue (states
// INIT0, INIT1); req.ready stays low meanwhile. Heap top resets to word 2.
// A finished response is held in an output register; while rsp is stalled
// the block can accept and work the next request, and it waits only when
// that next response is ready before the previous one is taken.
module boundary_tag_first_fit_allocator_top #(
    parameter int HEAP_WORDS = bta_pkg::HEAP_WORDS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bta_req_if.sink   req,
    bta_rsp_if.source rsp
);

    localparam int AW   = $clog2(HEAP_WORDS);
    localparam int TW   = AW + 3;
    localparam int IW   = AW + 2;
    localparam int TOPW = AW + 1;
    localparam int NW   = bta_pkg::NSIZE_W;
    localparam int CW   = (IW > NW) ? IW + 1 : NW + 1;
    localparam int AD   = bta_pkg::ADDR_W;
    localparam int ROUND_ADD = bta_pkg::TAG_PAIR_BYTES + 7;

    bta_pkg::state_t state_reg, state_next;
    bta_pkg::tail_t  tail_reg, tail_next;
    bta_pkg::rsp_t   out_data_reg, out_data_next;

    logic [NW-1:0]   n_reg, n_next;
    logic [AD-1:0]   faddr_reg, faddr_next;
    logic [IW-1:0]   h_reg, h_next;
    logic [TW-1:0]   s_reg, s_next;
    logic [TW-1:0]   s2_reg, s2_next;
    logic            used_reg, used_next;
    logic [1:0]      step_reg, step_next;
    logic [TOPW-1:0] top_reg, top_next;
    logic [AD-1:0]   res_addr_reg, res_addr_next;
    logic            res_status_reg, res_status_next;
    logic            out_valid_reg, out_valid_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [TW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [TW-1:0]   mem_rdata;

    logic [TW-1:0]   rd_size;
    logic            rd_used;
    logic            fit;
    logic [TW-1:0]   split_rem;
    logic            split;
    logic            walk_end;
    logic            grow_fail;
    logic [CW-1:0]   fh_ext;
    logic            free_bad;
    logic [IW-1:0]   idx_foot1;
    logic [IW-1:0]   idx_tail;
    logic [IW-1:0]   idx_foot2;
    logic [1:0]      last_step;
    logic            out_free;
    logic [NW-1:0]   n_sum;

    function automatic logic [AW-1:0] wrap(input logic [IW-1:0] x);
        logic [IW-1:0] v;
        v = x;
        for (int i = 0; i < 6; i++)
        begin
            if (v >= IW'(HEAP_WORDS))
            begin
                v = v - IW'(HEAP_WORDS);
            end
        end
        return v[AW-1:0];
    endfunction

    bta_ram #(
        .WIDTH (TW),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_size   = {mem_rdata[TW-1:3], 3'b000};
    assign rd_used   = mem_rdata[0];
    assign fit       = !rd_used && (CW'(rd_size) >= CW'(n_reg));
    assign split_rem = rd_size - TW'(n_reg);
    assign split     = split_rem > TW'(bta_pkg::MIN_SPLIT_BYTES);
    assign walk_end  = CW'(h_reg) >= CW'(top_reg);
    assign grow_fail = (CW'(top_reg) + CW'(n_reg >> 2)) > CW'(HEAP_WORDS);
    assign fh_ext    = CW'(faddr_reg[AD-1:2]) - CW'(1);
    assign free_bad  = (CW'(faddr_reg[AD-1:2]) < CW'(2))
                    || (fh_ext >= (CW'(top_reg) - CW'(1)));
    assign idx_tail  = h_reg + IW'(s_reg >> 2);
    assign idx_foot1 = idx_tail - IW'(1);
    assign idx_foot2 = idx_tail + IW'(s2_reg >> 2) - IW'(1);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign n_sum     = NW'(req.data.request_bytes) + NW'(ROUND_ADD);

    always_comb
    begin
        case (tail_reg)
            bta_pkg::TAIL_SPLIT:    last_step = 2'd3;
            bta_pkg::TAIL_EPILOGUE: last_step = 2'd2;
            default:                last_step = 2'd1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bta_pkg::ST_INIT0: state_next = bta_pkg::ST_INIT1;
            bta_pkg::ST_INIT1: state_next = bta_pkg::ST_IDLE;
            bta_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.data.mode == bta_pkg::MODE_FREE) ?
                                 bta_pkg::ST_F_CHK : bta_pkg::ST_A_RD;
                end
            end
            bta_pkg::ST_A_RD:
                state_next = walk_end ? bta_pkg::ST_GROW : bta_pkg::ST_A_CHK;
            bta_pkg::ST_A_CHK:
            begin
                if (rd_size == '0)
                    state_next = bta_pkg::ST_GROW;
                else if (fit)
                    state_next = bta_pkg::ST_WRITE;
                else
                    state_next = bta_pkg::ST_A_RD;
            end
            bta_pkg::ST_GROW:
                state_next = grow_fail ? bta_pkg::ST_DONE : bta_pkg::ST_WRITE;
            bta_pkg::ST_F_CHK:
                state_next = free_bad ? bta_pkg::ST_DONE : bta_pkg::ST_F_HDR;
            bta_pkg::ST_F_HDR:
                state_next = (rd_size == '0) ? bta_pkg::ST_DONE : bta_pkg::ST_F_NRD;
            bta_pkg::ST_F_NRD: state_next = bta_pkg::ST_F_NXT;
            bta_pkg::ST_F_NXT: state_next = bta_pkg::ST_F_PRV;
            bta_pkg::ST_F_PRV: state_next = bta_pkg::ST_WRITE;
            bta_pkg::ST_WRITE:
            begin
                if (step_reg == last_step)
                    state_next = bta_pkg::ST_DONE;
            end
            bta_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = bta_pkg::ST_IDLE;
            end
            default: state_next = bta_pkg::ST_IDLE;
        endcase
    end

    // RAM control and handshake outputs
    always_comb
    begin
        req.ready = (state_reg == bta_pkg::ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = wrap(h_reg);
        case (state_reg)
            bta_pkg::ST_INIT0:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(0);
                mem_wdata = TW'(bta_pkg::BOUND_TAG);
            end
            bta_pkg::ST_INIT1:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(1);
                mem_wdata = TW'(bta_pkg::BOUND_TAG);
            end
            bta_pkg::ST_F_CHK: mem_raddr = wrap(IW'(fh_ext));
            bta_pkg::ST_F_NRD: mem_raddr = wrap(idx_tail);
            bta_pkg::ST_F_NXT: mem_raddr = wrap(h_reg - IW'(1));
            bta_pkg::ST_WRITE:
            begin
                mem_we = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        mem_waddr = wrap(h_reg);
                        mem_wdata = s_reg | TW'(used_reg);
                    end
                    2'd1:
                    begin
                        mem_waddr = wrap(idx_foot1);
                        mem_wdata = s_reg | TW'(used_reg);
                    end
                    2'd2:
                    begin
                        mem_waddr = wrap(idx_tail);
                        mem_wdata = (tail_reg == bta_pkg::TAIL_SPLIT) ?
                                    s2_reg : TW'(bta_pkg::BOUND_TAG);
                    end
                    default:
                    begin
                        mem_waddr = wrap(idx_foot2);
                        mem_wdata = s2_reg;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        n_next          = n_reg;
        faddr_next      = faddr_reg;
        h_next          = h_reg;
        s_next          = s_reg;
        s2_next         = s2_reg;
        used_next       = used_reg;
        tail_next       = tail_reg;
        step_next       = step_reg;
        top_next        = top_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        case (state_reg)
            bta_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    n_next          = {n_sum[NW-1:3], 3'b000};
                    faddr_next      = req.data.free_address;
                    h_next          = IW'(1);
                    step_next       = 2'd0;
                    res_addr_next   = '0;
                    res_status_next = bta_pkg::STATUS_OK;
                end
            end
            bta_pkg::ST_A_CHK:
            begin
                if (rd_size != '0)
                begin
                    if (fit)
                    begin
                        s_next        = split ? TW'(n_reg) : rd_size;
                        s2_next       = split_rem;
                        used_next     = 1'b1;
                        tail_next     = split ? bta_pkg::TAIL_SPLIT : bta_pkg::TAIL_NONE;
                        res_addr_next = AD'({h_reg + IW'(1), 2'b00});
                    end
                    else
                    begin
                        h_next = h_reg + IW'(rd_size >> 2);
                    end
                end
            end
            bta_pkg::ST_GROW:
            begin
                if (grow_fail)
                begin
                    res_status_next = bta_pkg::STATUS_NO_SPACE;
                end
                else
                begin
                    h_next        = IW'(top_reg) - IW'(1);
                    s_next        = TW'(n_reg);
                    used_next     = 1'b1;
                    tail_next     = bta_pkg::TAIL_EPILOGUE;
                    top_next      = top_reg + TOPW'(n_reg >> 2);
                    res_addr_next = AD'({top_reg, 2'b00});
                end
            end
            bta_pkg::ST_F_CHK: h_next = IW'(fh_ext);
            bta_pkg::ST_F_HDR: s_next = rd_size;
            bta_pkg::ST_F_NXT:
            begin
                if (!rd_used)
                    s_next = s_reg + rd_size;
            end
            bta_pkg::ST_F_PRV:
            begin
                used_next = 1'b0;
                tail_next = bta_pkg::TAIL_NONE;
                if (!rd_used)
                begin
                    h_next = h_reg - IW'(rd_size >> 2);
                    s_next = s_reg + rd_size;
                end
            end
            bta_pkg::ST_WRITE: step_next = step_reg + 2'd1;
            bta_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = '{payload_address: res_addr_reg,
                                       status: res_status_reg};
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bta_pkg::ST_INIT0;
            top_reg       <= TOPW'(bta_pkg::INIT_TOP);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        faddr_reg      <= faddr_next;
        h_reg          <= h_next;
        s_reg          <= s_next;
        s2_reg         <= s2_next;
        used_reg       <= used_next;
        tail_reg       <= tail_next;
        step_reg       <= step_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule
